FILE: rtl/range_add_range_sum_tree_macros.svh
// Assertion macros for the range-add range-sum tree.
`ifndef RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`ifndef SYNTHESIS
`define RARS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range_add_range_sum_tree: check failed");
`define RARS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range_add_range_sum_tree: check failed");
`else
`define RARS_ASSERT_IMP(lbl, ante, cons)
`define RARS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rars_pkg.sv
// Shared constants and types of the range-add range-sum tree.
package rars_pkg;
  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_NODES   = 4096;
  localparam int STK_DEPTH    = 32;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_ADD   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef struct packed {
    logic [11:0] node;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic        post;
  } frame_t;
endpackage

FILE: rtl/range_add_range_sum_tree.sv
// Top level: segment tree with pending-add marks, range add and range sum.
//
//  channel | dir | fields (low bit first)                          | accept
//  s_*     | in  | tdata: mode[1:0] left_index[11:2]                | tvalid & tready
//          |     |        right_index[21:12] operand_value[53:22]  |
//  m_*     | out | tdata: range_sum[31:0]                           | tvalid & tready
//  cfg_*   | in  | cfg_data: element_count[10:0]                    | cfg_valid & cfg_ready
//
// One item at a time. A load writes its element as the word is accepted. Add and
// query walk the tree with an explicit frame stack, one node visit after another,
// through the single read port of the node-sum and pending-add memories. A build
// sweeps both 4096-entry memories to zero and then visits every node. After reset
// the same clearing pass runs with s_tready low; cfg writes are taken at any time.
`include "range_add_range_sum_tree_macros.svh"
module range_add_range_sum_tree
  import rars_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // mode, left_index, right_index, operand_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // range_sum
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data   // element_count
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_POP, ST_DEC, ST_PM_MUL, ST_PM_WR, ST_BODY, ST_AC_WR,
    ST_CH0, ST_CH1, ST_SPLIT, ST_SPLIT2, ST_LEAF, ST_FIX1, ST_FIX2, ST_OUT
  } state_t;

  state_t state;

  // Configuration register.
  logic [10:0] element_count;
  logic [9:0]  n_m1;

  // Item word held while the tree is walked.
  mode_t       mode_q;
  logic [9:0]  l_q, r_q;
  logic [31:0] val_q;

  // Frame stack and current frame.
  frame_t      stk [STK_DEPTH];
  logic [4:0]  sp;
  logic [11:0] cur_node;
  logic [9:0]  cur_lo, cur_hi;
  logic        cur_post;

  logic [31:0] sreg, prod, padd, cadd, acc;
  logic        ch_ret;
  logic [12:0] clr_cnt;
  logic        clr_build;

  // Memories.
  logic [31:0] sums_mem [TREE_NODES];
  logic [31:0] pend_mem [TREE_NODES];
  logic [31:0] elem_mem [MAX_ELEMENTS];
  logic [31:0] sums_q, pend_q, elem_q;
  logic        sums_we, pend_we, elem_we;
  logic [11:0] sums_wa, sums_ra, pend_wa, pend_ra;
  logic [9:0]  elem_wa, elem_ra;
  logic [31:0] sums_wd, pend_wd, elem_wd;

  // Input word fields.
  logic [1:0]  in_mode;
  logic [9:0]  in_l, in_r;
  logic [31:0] in_val;
  logic        in_ok;
  logic        accept;

  logic [10:0] len;
  logic [9:0]  mid;
  logic [11:0] lchild, rchild;
  logic        leaf, disjoint, covered;
  frame_t      top, root, lframe, rframe;
  logic [42:0] mul_full;
  logic [31:0] mul_b;

  assign in_mode = s_tdata[1:0];
  assign in_l    = s_tdata[11:2];
  assign in_r    = s_tdata[21:12];
  assign in_val  = s_tdata[53:22];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Clamp the count into 1..MAX_ELEMENTS and keep the last index.
  always_comb begin
    if (element_count == 11'd0) begin
      n_m1 = 10'd0;
    end else if (element_count > 11'(MAX_ELEMENTS)) begin
      n_m1 = 10'(MAX_ELEMENTS - 1);
    end else begin
      n_m1 = 10'(element_count - 11'd1);
    end
  end

  assign in_ok = (in_l <= in_r) && (in_r <= n_m1);

  assign len      = {1'b0, cur_hi} - {1'b0, cur_lo} + 11'd1;
  assign mid      = 10'(({1'b0, cur_lo} + {1'b0, cur_hi}) >> 1);
  assign lchild   = {cur_node[10:0], 1'b0};
  assign rchild   = {cur_node[10:0], 1'b1};
  assign leaf     = (cur_lo == cur_hi);
  assign disjoint = (cur_lo > r_q) || (cur_hi < l_q);
  assign covered  = (l_q <= cur_lo) && (cur_hi <= r_q);
  assign top      = stk[sp - 5'd1];
  assign root     = '{node: 12'd1, lo: 10'd0, hi: n_m1, post: 1'b0};
  assign lframe   = '{node: lchild, lo: cur_lo, hi: mid, post: 1'b0};
  assign rframe   = '{node: rchild, lo: mid + 10'd1, hi: cur_hi, post: 1'b0};

  // One shared multiplier: length times pending mark or add amount.
  assign mul_b    = (state == ST_BODY) ? val_q : pend_q;
  assign mul_full = {32'd0, len} * {11'd0, mul_b};

  // Memory port control.
  always_comb begin
    sums_we = 1'b0;
    sums_wa = cur_node;
    sums_wd = 32'd0;
    sums_ra = cur_node;
    pend_we = 1'b0;
    pend_wa = cur_node;
    pend_wd = 32'd0;
    pend_ra = cur_node;
    elem_we = 1'b0;
    elem_wa = in_l;
    elem_wd = in_val;
    elem_ra = cur_lo;
    case (state)
      ST_CLR: begin
        sums_we = 1'b1;
        sums_wa = clr_cnt[11:0];
        pend_we = 1'b1;
        pend_wa = clr_cnt[11:0];
      end
      ST_IDLE: begin
        elem_we = accept && (in_mode == MODE_LOAD);
      end
      ST_DEC: begin
        if (cur_post) begin
          sums_ra = lchild;
        end
      end
      ST_PM_WR: begin
        if (padd != 32'd0) begin
          sums_we = 1'b1;
          sums_wd = sreg + prod;
          pend_we = 1'b1;
        end
        pend_ra = lchild;
      end
      ST_AC_WR: begin
        sums_we = 1'b1;
        sums_wd = sreg + prod;
        pend_ra = lchild;
      end
      ST_CH0: begin
        pend_we = 1'b1;
        pend_wa = lchild;
        pend_wd = pend_q + cadd;
        pend_ra = rchild;
      end
      ST_CH1: begin
        pend_we = 1'b1;
        pend_wa = rchild;
        pend_wd = pend_q + cadd;
      end
      ST_LEAF: begin
        sums_we = 1'b1;
        sums_wd = elem_q;
      end
      ST_FIX1: begin
        sums_ra = rchild;
      end
      ST_FIX2: begin
        sums_we = 1'b1;
        sums_wd = sreg + sums_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sums_we) sums_mem[sums_wa] <= sums_wd;
    sums_q <= sums_mem[sums_ra];
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_q <= pend_mem[pend_ra];
    if (elem_we) elem_mem[elem_wa] <= elem_wd;
    elem_q <= elem_mem[elem_ra];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= 11'(MAX_ELEMENTS);
    end else if (cfg_valid && cfg_ready) begin
      element_count <= cfg_data;
    end
  end

  // Tree walk sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= 13'd0;
      clr_build <= 1'b0;
      sp        <= 5'd0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the word once taken; ST_OUT drives the flag on its own.
      if (m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 13'd1;
          if (clr_cnt[11:0] == 12'(TREE_NODES - 1)) begin
            if (clr_build) begin
              stk[0] <= root;
              sp     <= 5'd1;
              state  <= ST_POP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_q <= mode_t'(in_mode);
            l_q    <= in_l;
            r_q    <= in_r;
            val_q  <= in_val;
            acc    <= 32'd0;
            case (mode_t'(in_mode))
              MODE_BUILD: begin
                clr_cnt   <= 13'd0;
                clr_build <= 1'b1;
                state     <= ST_CLR;
              end
              MODE_ADD: begin
                if (in_ok) begin
                  stk[0] <= root;
                  sp     <= 5'd1;
                  state  <= ST_POP;
                end
              end
              MODE_QUERY: begin
                if (in_ok) begin
                  stk[0] <= root;
                  sp     <= 5'd1;
                  state  <= ST_POP;
                end else begin
                  state <= ST_OUT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          if (sp == 5'd0) begin
            state <= (mode_q == MODE_QUERY) ? ST_OUT : ST_IDLE;
          end else begin
            cur_node <= top.node;
            cur_lo   <= top.lo;
            cur_hi   <= top.hi;
            cur_post <= top.post;
            state    <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (cur_post) begin
            state <= ST_FIX1;
          end else begin
            case (mode_q)
              MODE_BUILD: state <= leaf ? ST_LEAF : ST_SPLIT;
              MODE_QUERY: begin
                if (disjoint) begin
                  sp    <= sp - 5'd1;
                  state <= ST_POP;
                end else begin
                  state <= ST_PM_MUL;
                end
              end
              default: state <= ST_PM_MUL;
            endcase
          end
        end
        ST_PM_MUL: begin
          padd  <= pend_q;
          sreg  <= sums_q;
          prod  <= mul_full[31:0];
          state <= ST_PM_WR;
        end
        ST_PM_WR: begin
          if (padd != 32'd0) begin
            sreg <= sreg + prod;
            if (!leaf) begin
              cadd   <= padd;
              ch_ret <= 1'b0;
              state  <= ST_CH0;
            end else begin
              state <= ST_BODY;
            end
          end else begin
            state <= ST_BODY;
          end
        end
        ST_BODY: begin
          if (mode_q == MODE_QUERY) begin
            if (covered) begin
              acc   <= acc + sreg;
              sp    <= sp - 5'd1;
              state <= ST_POP;
            end else begin
              state <= ST_SPLIT;
            end
          end else if (disjoint) begin
            sp    <= sp - 5'd1;
            state <= ST_POP;
          end else if (covered) begin
            prod  <= mul_full[31:0];
            state <= ST_AC_WR;
          end else begin
            state <= ST_SPLIT;
          end
        end
        ST_AC_WR: begin
          if (!leaf) begin
            cadd   <= val_q;
            ch_ret <= 1'b1;
            state  <= ST_CH0;
          end else begin
            sp    <= sp - 5'd1;
            state <= ST_POP;
          end
        end
        ST_CH0: begin
          state <= ST_CH1;
        end
        ST_CH1: begin
          if (ch_ret) begin
            sp    <= sp - 5'd1;
            state <= ST_POP;
          end else begin
            state <= ST_BODY;
          end
        end
        ST_SPLIT: begin
          // Query needs no post step: replace the frame with both children.
          if (mode_q == MODE_QUERY) begin
            stk[sp - 5'd1] <= rframe;
            stk[sp]        <= lframe;
            sp             <= sp + 5'd1;
            state          <= ST_POP;
          end else begin
            stk[sp - 5'd1] <= '{node: cur_node, lo: cur_lo, hi: cur_hi, post: 1'b1};
            stk[sp]        <= rframe;
            state          <= ST_SPLIT2;
          end
        end
        ST_SPLIT2: begin
          stk[sp + 5'd1] <= lframe;
          sp             <= sp + 5'd2;
          state          <= ST_POP;
        end
        ST_LEAF: begin
          sp    <= sp - 5'd1;
          state <= ST_POP;
        end
        ST_FIX1: begin
          sreg  <= sums_q;
          state <= ST_FIX2;
        end
        ST_FIX2: begin
          sp    <= sp - 5'd1;
          state <= ST_POP;
        end
        ST_OUT: begin
          // Hold the sum until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= acc;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RARS_ASSERT_IMP(a_stack_room, state != ST_CLR, sp < 5'd30)
  `RARS_ASSERT_NXT(a_query_done, (state == ST_POP) && (sp == 5'd0) && (mode_q == MODE_QUERY), state == ST_OUT)
  `RARS_ASSERT_IMP(a_no_take_in_clear, state == ST_CLR, !s_tready)

endmodule
